FILE: hw/rtl/papc_pkg.sv
// Shared types, status codes and the exp2 constant table for the option pricer.
`default_nettype none

package papc_pkg;

    // Status codes of a result beat
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDEF = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    localparam logic [47:0] PRICE_MAX = '1;

    // Input beat
    typedef struct packed {
        logic               mode;
        logic        [31:0] strike_price;
        logic        [31:0] volatility;
        logic signed [31:0] riskfree_rate;
        logic signed [31:0] carry_rate;
        logic        [31:0] spot_price;
    } req_t;

    // Result beat
    typedef struct packed {
        logic [47:0] price;
        logic [1:0]  status;
    } rsp_t;

    // Classified job handed from the front part to the engine
    typedef struct packed {
        logic               mode;
        logic        [31:0] strike_price;
        logic signed [31:0] riskfree_rate;
        logic signed [31:0] carry_rate;
        logic        [31:0] spot_price;
        logic        [63:0] vsq;
        logic               undef;
    } job_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef logic [31:0][63:0] exp_tab_t;

    // Q2.62 constants 2^(2^-i), i = 1..32, each the floor root of the one before
    function automatic exp_tab_t exp_table();
        exp_tab_t     tab;
        logic [127:0] rad;
        logic [127:0] sq;
        logic [63:0]  r;
        logic [63:0]  tt;
        rad = 128'd1 << 125;
        for (int i = 0; i < 32; i++)
        begin
            r = '0;
            for (int bi = 63; bi >= 0; bi--)
            begin
                tt = r | (64'd1 << bi);
                sq = 128'(tt) * 128'(tt);
                if (sq <= rad)
                begin
                    r = tt;
                end
            end
            tab[i] = r;
            rad = 128'(r) << 62;
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB = exp_table();

endpackage

`default_nettype wire

FILE: hw/rtl/perpetual_american_option_price_core.sv
// Top level of the perpetual American option pricer: front part, job queue, engine.
//
// Channel   Direction  Handshake                Payload
// request   in         start, busy              req    (papc_pkg::req_t)
// result    out        done (one-cycle strobe)  result (papc_pkg::rsp_t)
//
// A request beat is taken at a clock edge with start high and busy low.
// The front part registers each beat and the queue holds QUEUE_DEPTH jobs, so
// beats keep coming in while the engine works. busy rises only when both are full.
// A priced job runs two 48-step divisions (skipped when the ratio caps), a 48-step
// square root, four 32-step logarithms each after a normalize loop and 32 exp2
// steps, every 64-bit product being four passes through the one 32x32 multiplier.
// Jobs with zero sigma or strike finish in the idle state without running the pricing steps.
// Reset (rst_n low) empties the queue and idles the engine; the receiver cannot stall.
`default_nettype none

module perpetual_american_option_price_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire papc_pkg::req_t req,
    output logic                busy,
    output logic                done,
    output papc_pkg::rsp_t      result
);

    papc_pkg::q_stat_t qstat;
    papc_pkg::job_t    push_job;
    papc_pkg::job_t    pop_job;
    logic              push;
    logic              pop;

    papc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .busy     (busy),
        .qstat    (qstat),
        .push     (push),
        .push_job (push_job)
    );

    papc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .qstat    (qstat)
    );

    papc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .job    (pop_job),
        .qstat  (qstat),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/papc_front.sv
// Front part: accepts input beats, squares sigma and flags zero sigma or strike.
`default_nettype none

module papc_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire papc_pkg::req_t    req,
    output logic                   busy,
    input  wire papc_pkg::q_stat_t qstat,
    output logic                   push,
    output papc_pkg::job_t         push_job
);

    logic           stage_valid_reg;
    papc_pkg::job_t stage_reg;
    logic           accept;

    assign busy     = stage_valid_reg && qstat.full;
    assign accept   = start && !busy;
    assign push     = stage_valid_reg && !qstat.full;
    assign push_job = stage_reg;

    // Hold the stage flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    // Classify and register the beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg.mode          <= req.mode;
            stage_reg.strike_price  <= req.strike_price;
            stage_reg.riskfree_rate <= req.riskfree_rate;
            stage_reg.carry_rate    <= req.carry_rate;
            stage_reg.spot_price    <= req.spot_price;
            stage_reg.vsq           <= 64'(req.volatility) * 64'(req.volatility);
            stage_reg.undef         <= (req.volatility == '0) || (req.strike_price == '0);
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/papc_queue.sv
// Short job queue between the front part and the engine.
`default_nettype none

module papc_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire papc_pkg::job_t    push_job,
    input  wire logic              pop,
    output papc_pkg::job_t         pop_job,
    output papc_pkg::q_stat_t      qstat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    papc_pkg::job_t  slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign qstat.full  = (count_reg == CW'(DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign pop_job     = slot_reg[rd_ptr_reg];

    // Store pushed beats
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/papc_back.sv
// Engine: divisions, square root, logarithms and exp2 on one shared 32x32 multiplier.
`default_nettype none

module papc_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire papc_pkg::job_t    job,
    input  wire papc_pkg::q_stat_t qstat,
    output logic                   pop,
    output logic                   done,
    output papc_pkg::rsp_t         result
);

    typedef enum logic [3:0] {
        S_IDLE, S_DPREP, S_DIV, S_CSQ, S_SQRT, S_CHECK,
        S_LNORM, S_LSQ, S_PROD, S_TCHK, S_EXP, S_DONE
    } state_t;

    localparam logic signed [63:0] HALF_Q32 = 64'sh0000_0000_8000_0000;
    localparam logic signed [63:0] ONE_Q32  = 64'sh0000_0001_0000_0000;
    localparam logic signed [47:0] T_BIAS   = 48'sh0020_0000_0000;
    localparam logic signed [47:0] T_SAT    = 48'sh0030_0000_0000;
    localparam logic [63:0]        RATIO_CAP = 64'd1 << 47;

    state_t             state_reg;
    papc_pkg::job_t     job_reg;
    logic               div_sel_reg;
    logic [63:0]        rem_reg;
    logic [47:0]        quo_reg;
    logic [5:0]         it_reg;
    logic signed [63:0] a_reg;
    logic signed [63:0] q_reg;
    logic [95:0]        rad_reg;
    logic [51:0]        srem_reg;
    logic [47:0]        root_reg;
    logic signed [63:0] y_reg;
    logic [63:0]        ym1_reg;
    logic [63:0]        ya_reg;
    logic [1:0]         log_sel_reg;
    logic [63:0]        w_reg;
    logic [5:0]         p_reg;
    logic [63:0]        m_reg;
    logic [31:0]        frac_reg;
    logic signed [39:0] lk_reg;
    logic signed [39:0] ls_reg;
    logic signed [39:0] lm_reg;
    logic signed [39:0] ly_reg;
    logic signed [47:0] t_reg;
    logic [63:0]        mant_reg;
    logic [1:0]         cnt_reg;
    logic [127:0]       acc_reg;
    logic               done_reg;
    papc_pkg::rsp_t     result_reg;

    // Shared multiplier: one 32x32 partial product per cycle while a multiplying state is active
    logic [63:0]  mul_a;
    logic [63:0]  mul_b;
    logic [31:0]  mul_ah;
    logic [31:0]  mul_bh;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [127:0] prod_full;
    logic [63:0]  sq;
    logic         mul_active;
    logic         mul_last;

    // Division
    logic [31:0]        div_mag;
    logic               div_neg;
    logic [63:0]        div_capchk;
    logic               div_cap;
    logic [63:0]        div_rem0;
    logic [64:0]        rem2;
    logic               div_ge;
    logic [63:0]        rem_sub;
    logic [47:0]        quo_next;
    logic [63:0]        ratio_mag;
    logic signed [63:0] ratio_val;

    // Roots
    logic signed [63:0] c_val;
    logic [63:0]        cm;
    logic signed [63:0] disc;
    logic [51:0]        s_rem2;
    logic [51:0]        trial;
    logic               sge;
    logic [47:0]        root_new;
    logic signed [63:0] y_new;
    logic               y_undef;

    // Logs and exponent
    logic               norm_done;
    logic [31:0]        frac_next;
    logic [39:0]        log_val;
    logic [63:0]        log_src;
    logic signed [41:0] lt;
    logic [41:0]        lmag;
    logic [40:0]        pm;
    logic signed [47:0] pm_s;
    logic               t_neg;
    logic signed [47:0] t_new;
    logic [4:0]         fbit_idx;
    logic               exp_bit;
    logic [5:0]         out_sh;
    logic [47:0]        price_val;

    assign pop    = (state_reg == S_IDLE) && !qstat.empty;
    assign done   = done_reg;
    assign result = result_reg;

    // Select multiplier operands
    always_comb
    begin
        case (state_reg)
            S_CSQ:
            begin
                mul_a = cm;
                mul_b = cm;
            end
            S_LSQ:
            begin
                mul_a = m_reg;
                mul_b = m_reg;
            end
            S_PROD:
            begin
                mul_a = ya_reg;
                mul_b = 64'(lmag);
            end
            S_EXP:
            begin
                mul_a = mant_reg;
                mul_b = papc_pkg::EXP_TAB[it_reg[4:0]];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign fbit_idx   = 5'd31 - it_reg[4:0];
    assign exp_bit    = t_reg[fbit_idx];
    assign mul_active = (state_reg inside {S_CSQ, S_LSQ, S_PROD}) ||
                        ((state_reg == S_EXP) && exp_bit);
    assign mul_last   = mul_active && (cnt_reg == 2'd3);
    assign mul_ah     = cnt_reg[1] ? mul_a[63:32] : mul_a[31:0];
    assign mul_bh     = cnt_reg[0] ? mul_b[63:32] : mul_b[31:0];
    assign pp         = 64'(mul_ah) * 64'(mul_bh);

    always_comb
    begin
        case (cnt_reg)
            2'd0:    pp_sh = 128'(pp);
            2'd3:    pp_sh = 128'(pp) << 64;
            default: pp_sh = 128'(pp) << 32;
        endcase
    end

    assign prod_full = acc_reg + pp_sh;
    assign sq        = prod_full[125:62];

    // Ratio b / sigma^2 or 2r / sigma^2, one quotient bit a cycle
    always_comb
    begin
        div_neg    = div_sel_reg ? job_reg.riskfree_rate[31] : job_reg.carry_rate[31];
        div_mag    = div_sel_reg ? 32'(job_reg.riskfree_rate[31] ? -job_reg.riskfree_rate
                                                                  : job_reg.riskfree_rate)
                                 : 32'(job_reg.carry_rate[31] ? -job_reg.carry_rate
                                                               : job_reg.carry_rate);
        div_capchk = div_sel_reg ? (64'(div_mag) << 14) : (64'(div_mag) << 13);
        div_cap    = div_capchk >= job_reg.vsq;
        div_rem0   = div_sel_reg ? (64'(div_mag) << 13) : (64'(div_mag) << 12);
        rem2       = {rem_reg, 1'b0};
        div_ge     = rem2 >= {1'b0, job_reg.vsq};
        rem_sub    = 64'(rem2 - {1'b0, job_reg.vsq});
        quo_next   = {quo_reg[46:0], div_ge};
        ratio_mag  = (state_reg == S_DPREP) ? RATIO_CAP : 64'(quo_next);
        ratio_val  = div_neg ? -$signed(ratio_mag) : $signed(ratio_mag);
    end

    // Discriminant, square root and root selection
    always_comb
    begin
        c_val    = HALF_Q32 - a_reg;
        cm       = c_val[63] ? 64'(-c_val) : 64'(c_val);
        disc     = $signed(prod_full[95:32]) + q_reg;
        s_rem2   = {srem_reg[49:0], rad_reg[95:94]};
        trial    = {2'b00, root_reg, 2'b01};
        sge      = s_rem2 >= trial;
        root_new = {root_reg[46:0], sge};
        y_new    = job_reg.mode ? c_val - $signed(64'(root_new))
                                : c_val + $signed(64'(root_new));
        y_undef  = job_reg.mode ? (y_reg >= 0) : (y_reg <= ONE_Q32);
    end

    // Logarithm steps and the exponent
    always_comb
    begin
        norm_done = w_reg[63] || (p_reg == '0);
        frac_next = {frac_reg[30:0], sq[63]};
        log_val   = {2'b00, p_reg, frac_next};
        case (log_sel_reg)
            2'd0:    log_src = 64'(job_reg.spot_price);
            2'd1:    log_src = ym1_reg;
            default: log_src = ya_reg;
        endcase
        lt        = 42'(ls_reg) - 42'(lk_reg) + 42'(lm_reg) - 42'(ly_reg);
        lmag      = lt[41] ? 42'(-lt) : 42'(lt);
        pm        = (prod_full[127:72] != '0) ? (41'd1 << 40) : {1'b0, prod_full[71:32]};
        pm_s      = $signed(48'(pm));
        t_neg     = job_reg.mode ^ lt[41];
        t_new     = 48'(lk_reg) - 48'(lm_reg) + T_BIAS + (t_neg ? -pm_s : pm_s);
        out_sh    = 6'd62 - t_reg[37:32];
        price_val = 48'(mant_reg >> out_sh);
    end

    // Sequence one job and hold the result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
            acc_reg     <= '0;
            it_reg      <= '0;
            div_sel_reg <= 1'b0;
            log_sel_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (mul_active)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                acc_reg <= mul_last ? '0 : prod_full;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (!qstat.empty)
                    begin
                        job_reg <= job;
                        if (job.undef)
                        begin
                            done_reg   <= 1'b1;
                            result_reg <= papc_pkg::rsp_t'{price: '0,
                                                           status: papc_pkg::ST_UNDEF};
                        end
                        else
                        begin
                            div_sel_reg <= 1'b0;
                            state_reg   <= S_DPREP;
                        end
                    end
                end
                S_DPREP:
                begin
                    if (div_cap)
                    begin
                        if (div_sel_reg)
                        begin
                            q_reg     <= ratio_val;
                            state_reg <= S_CSQ;
                        end
                        else
                        begin
                            a_reg       <= ratio_val;
                            div_sel_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        rem_reg   <= div_rem0;
                        quo_reg   <= '0;
                        it_reg    <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= div_ge ? rem_sub : rem2[63:0];
                    quo_reg <= quo_next;
                    if (it_reg == 6'd47)
                    begin
                        it_reg <= '0;
                        if (div_sel_reg)
                        begin
                            q_reg     <= ratio_val;
                            state_reg <= S_CSQ;
                        end
                        else
                        begin
                            a_reg       <= ratio_val;
                            div_sel_reg <= 1'b1;
                            state_reg   <= S_DPREP;
                        end
                    end
                    else
                    begin
                        it_reg <= it_reg + 1'b1;
                    end
                end
                S_CSQ:
                begin
                    if (mul_last)
                    begin
                        if (disc[63])
                        begin
                            done_reg   <= 1'b1;
                            result_reg <= papc_pkg::rsp_t'{price: '0,
                                                           status: papc_pkg::ST_UNDEF};
                            state_reg  <= S_IDLE;
                        end
                        else
                        begin
                            rad_reg   <= {disc, 32'd0};
                            srem_reg  <= '0;
                            root_reg  <= '0;
                            it_reg    <= '0;
                            state_reg <= S_SQRT;
                        end
                    end
                end
                S_SQRT:
                begin
                    rad_reg  <= {rad_reg[93:0], 2'b00};
                    srem_reg <= sge ? s_rem2 - trial : s_rem2;
                    root_reg <= root_new;
                    it_reg   <= it_reg + 1'b1;
                    if (it_reg == 6'd47)
                    begin
                        y_reg     <= y_new;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (y_undef)
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= papc_pkg::rsp_t'{price: '0,
                                                       status: papc_pkg::ST_UNDEF};
                        state_reg  <= S_IDLE;
                    end
                    else if (job_reg.spot_price == '0)
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= job_reg.mode
                                      ? papc_pkg::rsp_t'{price: papc_pkg::PRICE_MAX,
                                                         status: papc_pkg::ST_SAT}
                                      : papc_pkg::rsp_t'{price: '0,
                                                         status: papc_pkg::ST_OK};
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        ym1_reg     <= job_reg.mode ? 64'(ONE_Q32 - y_reg) : 64'(y_reg - ONE_Q32);
                        ya_reg      <= job_reg.mode ? 64'(-y_reg) : 64'(y_reg);
                        log_sel_reg <= '0;
                        w_reg       <= 64'(job_reg.strike_price);
                        p_reg       <= 6'd63;
                        state_reg   <= S_LNORM;
                    end
                end
                S_LNORM:
                begin
                    if (norm_done)
                    begin
                        m_reg     <= w_reg >> 1;
                        frac_reg  <= '0;
                        it_reg    <= '0;
                        state_reg <= S_LSQ;
                    end
                    else if ((w_reg[63:56] == '0) && (p_reg >= 6'd8))
                    begin
                        w_reg <= w_reg << 8;
                        p_reg <= p_reg - 6'd8;
                    end
                    else
                    begin
                        w_reg <= w_reg << 1;
                        p_reg <= p_reg - 6'd1;
                    end
                end
                S_LSQ:
                begin
                    if (mul_last)
                    begin
                        m_reg    <= sq[63] ? (sq >> 1) : sq;
                        frac_reg <= frac_next;
                        it_reg   <= it_reg + 1'b1;
                        if (it_reg == 6'd31)
                        begin
                            case (log_sel_reg)
                                2'd0:    lk_reg <= $signed(log_val);
                                2'd1:    ls_reg <= $signed(log_val);
                                2'd2:    lm_reg <= $signed(log_val);
                                default: ly_reg <= $signed(log_val);
                            endcase
                            if (log_sel_reg == 2'd3)
                            begin
                                state_reg <= S_PROD;
                            end
                            else
                            begin
                                log_sel_reg <= log_sel_reg + 1'b1;
                                w_reg       <= log_src;
                                p_reg       <= 6'd63;
                                state_reg   <= S_LNORM;
                            end
                        end
                    end
                end
                S_PROD:
                begin
                    if (mul_last)
                    begin
                        t_reg     <= t_new;
                        state_reg <= S_TCHK;
                    end
                end
                S_TCHK:
                begin
                    if (t_reg[47])
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= papc_pkg::rsp_t'{price: '0, status: papc_pkg::ST_OK};
                        state_reg  <= S_IDLE;
                    end
                    else if (t_reg >= T_SAT)
                    begin
                        done_reg   <= 1'b1;
                        result_reg <= papc_pkg::rsp_t'{price: papc_pkg::PRICE_MAX,
                                                       status: papc_pkg::ST_SAT};
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        mant_reg  <= 64'd1 << 62;
                        it_reg    <= '0;
                        state_reg <= S_EXP;
                    end
                end
                S_EXP:
                begin
                    if (!exp_bit || mul_last)
                    begin
                        if (exp_bit)
                        begin
                            mant_reg <= sq;
                        end
                        if (it_reg == 6'd31)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            it_reg <= it_reg + 1'b1;
                        end
                    end
                end
                S_DONE:
                begin
                    done_reg   <= 1'b1;
                    result_reg <= papc_pkg::rsp_t'{price: price_val, status: papc_pkg::ST_OK};
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // An undefined job reports a zero price
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == papc_pkg::ST_UNDEF)) |-> (result.price == '0))
        else $error("undefined result with nonzero price");

    // A saturated job reports the full-scale price
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == papc_pkg::ST_SAT)) |-> (result.price == papc_pkg::PRICE_MAX))
        else $error("saturated result without full-scale price");

    // Every result beat carries a defined status code
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result.status == papc_pkg::ST_OK) || (result.status == papc_pkg::ST_UNDEF) ||
                  (result.status == papc_pkg::ST_SAT)))
        else $error("result beat with unused status code");

    // Partial products only run in multiplying states
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != 2'd0) |-> ((state_reg == S_CSQ) || (state_reg == S_LSQ) ||
                               (state_reg == S_PROD) || (state_reg == S_EXP)))
        else $error("multiplier pass left open outside a multiplying state");

endmodule

`default_nettype wire
